FILE: design/assert_macros.svh
// Assertion macros shared by the Playfair encryptor RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/pf_pkg.sv
// Types, constants and letter helpers for the Playfair encryptor.
// No dependencies; used by pf_square and playfair_digraph_encryptor.
`default_nettype none

package pf_pkg;

    localparam logic [1:0] CMD_NEW_KEY = 2'd0;
    localparam logic [1:0] CMD_KEY     = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;
    localparam logic [1:0] CMD_END     = 2'd3;

    localparam int         N_LETTERS = 26;
    localparam int         SQ_CELLS  = 25;
    localparam logic [4:0] IDX_I     = 5'd8;
    localparam logic [4:0] IDX_J     = 5'd9;
    localparam logic [4:0] IDX_X     = 5'd23;
    localparam logic [4:0] LAST_IDX  = 5'd25;
    localparam logic [4:0] FULL_CNT  = 5'd25;
    localparam logic [2:0] LAST_RC   = 3'd4;
    localparam logic [4:0] SIDE      = 5'd5;

    localparam logic [7:0] ASC_UP_A  = 8'h41;
    localparam logic [7:0] ASC_UP_Z  = 8'h5A;
    localparam logic [7:0] ASC_LO_A  = 8'h61;
    localparam logic [7:0] ASC_LO_Z  = 8'h7A;
    localparam logic [6:0] ASC7_A    = 7'h41;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] letter;
    } t_in;

    typedef struct packed {
        logic [6:0] cipher_letter;
        logic       pair_end;
    } t_out;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } t_fold;

    // Control from the sequencer to the square store.
    typedef struct packed {
        logic       clear;
        logic       place;
        logic [4:0] place_idx;
    } t_sq_ctrl;

    function automatic t_fold fold_letter(input logic [7:0] b);
        t_fold f;
        f.ok  = 1'b1;
        f.idx = 5'd0;
        if (b >= ASC_UP_A && b <= ASC_UP_Z) begin
            f.idx = 5'(b - ASC_UP_A);
        end else if (b >= ASC_LO_A && b <= ASC_LO_Z) begin
            f.idx = 5'(b - ASC_LO_A);
        end else begin
            f.ok = 1'b0;
        end
        if (f.idx == IDX_J) begin
            f.idx = IDX_I;
        end
        return f;
    endfunction

    function automatic logic [2:0] pos_row(input logic [4:0] pos);
        logic [2:0] r;
        if (pos < 5'd5) begin
            r = 3'd0;
        end else if (pos < 5'd10) begin
            r = 3'd1;
        end else if (pos < 5'd15) begin
            r = 3'd2;
        end else if (pos < 5'd20) begin
            r = 3'd3;
        end else begin
            r = 3'd4;
        end
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] pos);
        logic [4:0] base;
        base = 5'({2'b00, pos_row(pos)} * SIDE);
        return 3'(pos - base);
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == LAST_RC) ? 3'd0 : 3'(v + 3'd1);
    endfunction

    function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
        return 5'({2'b00, r} * SIDE) + {2'b00, c};
    endfunction

endpackage

`default_nettype wire

FILE: design/pf_square.sv
// Key square store: cell table and letter position memories, used flags
// and fill count, with one placement unit. Depends on pf_pkg.
`default_nettype none
`include "assert_macros.svh"

module pf_square (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pf_pkg::t_sq_ctrl  i_ctrl,
    input  wire logic [4:0]        i_pos_addr_a,
    input  wire logic [4:0]        i_pos_addr_b,
    input  wire logic [4:0]        i_cell_addr_a,
    input  wire logic [4:0]        i_cell_addr_b,
    output logic [4:0]             o_pos_a,
    output logic [4:0]             o_pos_b,
    output logic [4:0]             o_cell_a,
    output logic [4:0]             o_cell_b
);
    import pf_pkg::*;

    logic [4:0]           cell_mem [SQ_CELLS];
    logic [4:0]           pos_mem  [N_LETTERS];
    logic [N_LETTERS-1:0] r_used;
    logic [N_LETTERS-1:0] n_used;
    logic [4:0]           r_fill;
    logic [4:0]           n_fill;
    logic                 do_place;

    // A letter takes the next cell only if it is new and a cell is free.
    assign do_place = i_ctrl.place && !i_ctrl.clear && (i_ctrl.place_idx <= LAST_IDX)
                      && !r_used[i_ctrl.place_idx] && (r_fill < FULL_CNT);

    always_comb begin
        n_used = r_used;
        n_fill = r_fill;
        if (i_ctrl.clear) begin
            n_used = '0;
            n_fill = 5'd0;
        end else if (do_place) begin
            n_used[i_ctrl.place_idx] = 1'b1;
            n_fill = 5'(r_fill + 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_fill <= 5'd0;
        end else begin
            r_used <= n_used;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_place) begin
            cell_mem[r_fill]          <= i_ctrl.place_idx;
            pos_mem[i_ctrl.place_idx] <= r_fill;
        end
        o_pos_a  <= pos_mem[i_pos_addr_a];
        o_pos_b  <= pos_mem[i_pos_addr_b];
        o_cell_a <= cell_mem[i_cell_addr_a];
        o_cell_b <= cell_mem[i_cell_addr_b];
    end

    `ASSERT_ALWAYS(a_fill_matches_used, i_clk, i_rst_n, ($countones(r_used) == int'(r_fill)), "fill count differs from used letters")
    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, (r_fill <= FULL_CNT), "fill count beyond square size")
    `ASSERT_ALWAYS(a_j_never_used, i_clk, i_rst_n, (!r_used[IDX_J]), "letter J placed in square")

endmodule

`default_nettype wire

FILE: design/playfair_digraph_encryptor.sv
// Top level of the Playfair encryptor: command sequencer, pairing logic
// and two-entry result register. Depends on pf_pkg and pf_square.
//
//  channel | direction | handshake                 | payload
//  input   | in        | i_in_valid / o_in_ready   | i_in  (cmd, letter)
//  output  | out       | o_out_valid / i_out_ready | o_out (cipher_letter, pair_end)
//
// New key and key letter commands are handled without leaving S_IDLE. The first text letter or
// end of message after a key walks the alphabet through the placement unit
// in S_FILL. A text letter that completes a pair passes through pair
// selection, two position reads, two cell reads and the result load.
// Reset is synchronous and active low; the square is unusable until a key
// or text arrives. A stalled output holds the sequencer only at the load.
`default_nettype none
`include "assert_macros.svh"

module playfair_digraph_encryptor (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pf_pkg::t_in   i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pf_pkg::t_out       o_out
);
    import pf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FILL = 6'b000010,
        S_TEXT = 6'b000100,
        S_POS  = 6'b001000,
        S_CELL = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cmd, n_cmd;
    logic [4:0] r_idx, n_idx;
    logic       r_complete, n_complete;
    logic       r_pend, n_pend;
    logic [4:0] r_pend_letter, n_pend_letter;
    logic [4:0] r_walk, n_walk;
    logic [4:0] r_let_a, n_let_a;
    logic [4:0] r_let_b, n_let_b;
    t_out       r_out_q0, n_out_q0;
    t_out       r_out_q1, n_out_q1;
    logic [1:0] r_out_cnt, n_out_cnt;

    t_sq_ctrl   sq_ctrl;
    t_fold      fold;
    logic       in_xfer;
    logic       out_xfer;
    logic [4:0] pos_a, pos_b, cell_a, cell_b;
    logic [2:0] r1, c1, r2, c2;
    logic [4:0] caddr_a, caddr_b;

    assign fold       = fold_letter(i_in.letter);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_out_cnt != 2'd0);
    assign o_out      = r_out_q0;
    assign out_xfer   = o_out_valid && i_out_ready;

    // Same-row, same-column and rectangle rules on the registered positions.
    always_comb begin
        r1 = pos_row(pos_a);
        c1 = pos_col(pos_a);
        r2 = pos_row(pos_b);
        c2 = pos_col(pos_b);
        if (r1 == r2) begin
            caddr_a = cell_addr(r1, wrap_inc(c1));
            caddr_b = cell_addr(r2, wrap_inc(c2));
        end else if (c1 == c2) begin
            caddr_a = cell_addr(wrap_inc(r1), c1);
            caddr_b = cell_addr(wrap_inc(r2), c2);
        end else begin
            caddr_a = cell_addr(r1, c2);
            caddr_b = cell_addr(r2, c1);
        end
    end

    pf_square u_square (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (sq_ctrl),
        .i_pos_addr_a  (r_let_a),
        .i_pos_addr_b  (r_let_b),
        .i_cell_addr_a (caddr_a),
        .i_cell_addr_b (caddr_b),
        .o_pos_a       (pos_a),
        .o_pos_b       (pos_b),
        .o_cell_a      (cell_a),
        .o_cell_b      (cell_b)
    );

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        n_complete    = r_complete;
        n_pend        = r_pend;
        n_pend_letter = r_pend_letter;
        n_walk        = r_walk;
        n_let_a       = r_let_a;
        n_let_b       = r_let_b;
        n_out_q0      = r_out_q0;
        n_out_q1      = r_out_q1;
        n_out_cnt     = r_out_cnt;
        sq_ctrl       = '0;

        if (out_xfer) begin
            n_out_q0  = r_out_q1;
            n_out_cnt = 2'(r_out_cnt - 2'd1);
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd  = i_in.cmd;
                    n_idx  = fold.idx;
                    n_walk = 5'd0;
                    case (i_in.cmd)
                        CMD_NEW_KEY: begin
                            sq_ctrl.clear = 1'b1;
                            n_complete    = 1'b0;
                            n_pend        = 1'b0;
                        end
                        CMD_KEY: begin
                            sq_ctrl.place     = !r_complete && fold.ok;
                            sq_ctrl.place_idx = fold.idx;
                        end
                        CMD_TEXT: begin
                            if (fold.ok) begin
                                n_state = r_complete ? S_TEXT : S_FILL;
                            end
                        end
                        default: begin
                            n_state = r_complete ? S_TEXT : S_FILL;
                        end
                    endcase
                end
            end
            S_FILL: begin
                // One alphabet letter per cycle through the placement unit.
                sq_ctrl.place     = (r_walk != IDX_J);
                sq_ctrl.place_idx = r_walk;
                n_walk            = 5'(r_walk + 5'd1);
                if (r_walk == LAST_IDX) begin
                    n_complete = 1'b1;
                    n_state    = S_TEXT;
                end
            end
            S_TEXT: begin
                n_state = S_IDLE;
                if (r_cmd == CMD_TEXT) begin
                    if (!r_pend) begin
                        n_pend        = 1'b1;
                        n_pend_letter = r_idx;
                    end else begin
                        n_let_a = r_pend_letter;
                        n_state = S_POS;
                        // A doubled letter gets an X and starts the next pair.
                        if (r_pend_letter == r_idx) begin
                            n_let_b = IDX_X;
                        end else begin
                            n_let_b = r_idx;
                            n_pend  = 1'b0;
                        end
                    end
                end else if (r_pend) begin
                    n_let_a = r_pend_letter;
                    n_let_b = IDX_X;
                    n_pend  = 1'b0;
                    n_state = S_POS;
                end
            end
            S_POS: begin
                n_state = S_CELL;
            end
            S_CELL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_out_cnt == 2'd0) begin
                    n_out_q0.cipher_letter = ASC7_A + {2'b00, cell_a};
                    n_out_q0.pair_end      = 1'b0;
                    n_out_q1.cipher_letter = ASC7_A + {2'b00, cell_b};
                    n_out_q1.pair_end      = 1'b1;
                    n_out_cnt              = 2'd2;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_complete    <= 1'b0;
            r_pend        <= 1'b0;
            r_pend_letter <= 5'd0;
            r_out_cnt     <= 2'd0;
        end else begin
            r_state       <= n_state;
            r_complete    <= n_complete;
            r_pend        <= n_pend;
            r_pend_letter <= n_pend_letter;
            r_out_cnt     <= n_out_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_walk   <= n_walk;
        r_let_a  <= n_let_a;
        r_let_b  <= n_let_b;
        r_out_q0 <= n_out_q0;
        r_out_q1 <= n_out_q1;
    end

    `ASSERT_NEXT(a_emit_loads_pair, i_clk, i_rst_n, (r_state == S_EMIT && r_out_cnt == 2'd0), (r_out_cnt == 2'd2 && r_state == S_IDLE), "result pair not loaded")
    `ASSERT_IMPLY(a_pair_needs_square, i_clk, i_rst_n, (r_state == S_POS || r_state == S_CELL || r_state == S_EMIT), r_complete, "pair encrypted before square complete")
    `ASSERT_IMPLY(a_pair_order, i_clk, i_rst_n, (r_out_cnt == 2'd2), (!r_out_q0.pair_end && r_out_q1.pair_end), "pair letters out of order")
    `ASSERT_IMPLY(a_walk_bound, i_clk, i_rst_n, (r_state == S_FILL), (r_walk <= LAST_IDX && !r_complete), "alphabet walk out of range")

endmodule

`default_nettype wire
